/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define OAT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define OAT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

/* rtl/oat_pkg.sv */
// types, constants and codes of the ordered array table
package oat_pkg;

   localparam int DEPTH = 16;
   localparam int WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // operation codes, selector value 7 is unused
   typedef enum logic [2:0] {
      FUNC_APPEND = 3'd0,
      FUNC_INSERT = 3'd1,
      FUNC_POP    = 3'd2,
      FUNC_DELETE = 3'd3,
      FUNC_REMOVE = 3'd4,
      FUNC_FIND   = 3'd5,
      FUNC_READ   = 3'd6
   } func_type;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  position;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic        found;
      logic [3:0]  found_index;
      logic [4:0]  removed_count;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_op;
      logic scan_end;
   } stat_type;

endpackage

/* rtl/oat_ctrl.sv */
// controller state machine of the ordered array table
module oat_ctrl import oat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_strobe
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.scan_op ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            if (stat.scan_end) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_EXEC: begin
            cmd.exec = !stat.scan_op;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/oat_datapath.sv */
// entry cells, count and result registers of the ordered array table
module oat_datapath import oat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [WIDTH-1:0]   entry_in [DEPTH];
   logic [1:0]         status_ff, status_in;
   logic [WIDTH-1:0]   read_ff, read_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   fidx_ff, fidx_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;

   logic               do_ins, do_del;
   logic [CNT_W-1:0]   ins_pos, del_base, pos_c;
   logic [WIDTH-1:0]   val, rdata;
   logic               in_range, hit, is_find, is_remove;

   assign val       = req_ff.item_value[WIDTH-1:0];
   assign pos_c     = CNT_W'(req_ff.position);
   assign rdata     = entry_ff[idx_ff[IDX_W-1:0]];
   assign in_range  = idx_ff < count_ff;
   assign hit       = in_range && (rdata == val);
   assign is_find   = req_ff.func == FUNC_FIND;
   assign is_remove = req_ff.func == FUNC_REMOVE;

   assign stat.scan_op  = is_find || is_remove;
   assign stat.scan_end = !in_range || (is_find && hit);

   // operation sequencing
   always_comb begin
      req_in     = req_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      read_in    = read_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      removed_in = removed_ff;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      ins_pos    = count_ff;
      del_base   = idx_ff;

      if (cmd.capture) begin
         req_in     = req_data;
         status_in  = STATUS_OK;
         read_in    = '0;
         found_in   = 1'b0;
         fidx_in    = '0;
         removed_in = '0;
         if (req_data.func == FUNC_POP) begin
            idx_in = count_ff - CNT_W'(1);
         end else if (req_data.func == FUNC_FIND || req_data.func == FUNC_REMOVE) begin
            idx_in = '0;
         end else begin
            idx_in = CNT_W'(req_data.position);
         end
      end

      if (cmd.exec) begin
         unique case (req_ff.func)
            FUNC_APPEND: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  do_ins   = 1'b1;
                  ins_pos  = count_ff;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FUNC_INSERT: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = STATUS_FULL;
               end else if (pos_c > count_ff) begin
                  status_in = STATUS_RANGE;
               end else begin
                  do_ins   = 1'b1;
                  ins_pos  = pos_c;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FUNC_POP: begin
               if (count_ff == '0) begin
                  status_in = STATUS_RANGE;
               end else begin
                  read_in  = rdata;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FUNC_DELETE: begin
               if (pos_c >= count_ff) begin
                  status_in = STATUS_RANGE;
               end else begin
                  do_del   = 1'b1;
                  del_base = pos_c;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FUNC_READ: begin
               if (pos_c >= count_ff) begin
                  status_in = STATUS_RANGE;
               end else begin
                  read_in = rdata;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end

      // one entry compared per cycle, a match on remove closes the gap
      if (cmd.scan) begin
         if (!stat.scan_end) begin
            if (hit) begin
               do_del     = 1'b1;
               del_base   = idx_ff;
               count_in   = count_ff - CNT_W'(1);
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end else if (is_find && hit) begin
            found_in = 1'b1;
            fidx_in  = idx_ff[IDX_W-1:0];
         end
      end
   end

   // entry cells: take the value, the left neighbor or the right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CI = CNT_W'(i);
      logic [WIDTH-1:0] prev_w, next_w;

      if (i > 0) begin : g_prev
         assign prev_w = entry_ff[i-1];
      end else begin : g_prev0
         assign prev_w = entry_ff[i];
      end

      if (i < DEPTH - 1) begin : g_next
         assign next_w = entry_ff[i+1];
      end else begin : g_next_last
         assign next_w = entry_ff[i];
      end

      always_comb begin
         entry_in[i] = entry_ff[i];
         if (do_ins) begin
            if (CI == ins_pos) begin
               entry_in[i] = val;
            end else if (CI > ins_pos && CI <= count_ff) begin
               entry_in[i] = prev_w;
            end
         end
         if (do_del && CI >= del_base && (CI + CNT_W'(1)) < count_ff) begin
            entry_in[i] = next_w;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         entry_ff[k] <= entry_in[k];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // request and result registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      read_ff    <= read_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      removed_ff <= removed_in;
   end

   // result fields
   assign rsp_data.status        = status_ff;
   assign rsp_data.read_value    = 32'(read_ff);
   assign rsp_data.found         = found_ff;
   assign rsp_data.found_index   = 4'(fidx_ff);
   assign rsp_data.removed_count = 5'(removed_ff);
   assign rsp_data.entry_count   = 5'(count_ff);
   assign rsp_data.is_empty      = count_ff == '0;

   // reset is read only through the control registers
   logic unused_reset;
   assign unused_reset = reset;

endmodule

/* rtl/ordered_array_table_core.sv */
// top level of the ordered array table
//
// A store of up to 16 words of 32 bits kept in order, with an entry count.
// Requests: drive req_data (func, position, item_value) and raise start;
// the item is taken at a clock edge where start is high and busy is low.
// Operations are append, insert at a position, pop, delete at a position,
// remove every match, find the first match and read at a position.
// Each item gives one result on rsp_data, shown for exactly one cycle
// while rsp_strobe is high; the receiver cannot stall it.
// Append, insert, pop, delete, read and the unused code pass from accept
// through the execute state to the strobe; find and remove pass on to a
// scan state that compares one entry per cycle through the single read
// port, for remove over every entry held, for find up to its first match.
// Shifts for insert and delete happen in parallel in the cell chain.
// busy stays high until the strobe cycle ends, so a new item is taken
// only once the result of the previous one has been shown.
// Reset clears the count and the controller; entry contents are not reset.
module ordered_array_table_core import oat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   oat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   oat_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/oat_checker.sv */
// port-level checks of the ordered array table and their binding
`include "assert_macros.svh"

module oat_checker import oat_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic accept;
   assign accept = start && !busy;

   // an accepted item keeps the block busy next cycle
   `OAT_ASSERT(a_accept_busy, clock, reset, accept |=> busy)

   // a result is shown only while the item is still in work
   `OAT_ASSERT(a_strobe_busy, clock, reset, rsp_strobe |-> busy)

   // a result strobe lasts one cycle and frees the block
   `OAT_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> (!rsp_strobe && !busy))

   // empty flag agrees with the entry count
   `OAT_ASSERT(a_empty_count, clock, reset,
      rsp_strobe |-> (rsp_data.is_empty == (rsp_data.entry_count == 5'd0)))

   // no status code beyond store full, and count never over capacity
   `OAT_NEVER(a_bad_result, clock, reset,
      rsp_strobe && (rsp_data.status == 2'd3 || rsp_data.entry_count > 5'(DEPTH)))

   logic [$bits(req_type)-1:0] unused_req;
   assign unused_req = req_data;

endmodule

bind ordered_array_table_core oat_checker u_oat_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

/* tb/testbench.sv */
// self-checking testbench for the ordered array table core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import oat_pkg::*;

   // selector value that maps to no operation
   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int PHASE_ITEMS = 288;
   // longest scan plus strobe and handshake turnaround
   localparam int SETTLE_CYCLES = 24;
   localparam int PRINT_LIMIT = 40;

   // predicts table results and checks them in order
   class table_scoreboard;
      logic [WIDTH-1:0] store [DEPTH];
      int held;
      int mismatches;
      rsp_type expected_results [$];

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      function void drop_entry(int idx);
         int i;
         for (i = idx; i + 1 < held; i++) begin
            store[i] = store[i + 1];
         end
         held--;
      endfunction

      // apply one request to the table copy and build its result
      function rsp_type predict_response(req_type r);
         rsp_type rsp;
         int i;
         int pos;
         rsp = '0;
         pos = int'(r.position);
         case (r.func)
            FUNC_APPEND: begin
               if (held >= DEPTH) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  store[held] = r.item_value;
                  held++;
               end
            end
            FUNC_INSERT: begin
               // full check comes before the index check
               if (held >= DEPTH) begin
                  rsp.status = STATUS_FULL;
               end else if (pos > held) begin
                  rsp.status = STATUS_RANGE;
               end else begin
                  for (i = held; i > pos; i--) begin
                     store[i] = store[i - 1];
                  end
                  store[pos] = r.item_value;
                  held++;
               end
            end
            FUNC_POP: begin
               if (held == 0) begin
                  rsp.status = STATUS_RANGE;
               end else begin
                  rsp.read_value = store[held - 1];
                  held--;
               end
            end
            FUNC_DELETE: begin
               if (pos >= held) begin
                  rsp.status = STATUS_RANGE;
               end else begin
                  drop_entry(pos);
               end
            end
            FUNC_REMOVE: begin
               i = 0;
               while (i < held) begin
                  if (store[i] == r.item_value) begin
                     drop_entry(i);
                     rsp.removed_count = rsp.removed_count + 5'd1;
                  end else begin
                     i++;
                  end
               end
            end
            FUNC_FIND: begin
               for (i = 0; i < held; i++) begin
                  if (store[i] == r.item_value && !rsp.found) begin
                     rsp.found = 1'b1;
                     rsp.found_index = 4'(i);
                  end
               end
            end
            FUNC_READ: begin
               if (pos >= held) begin
                  rsp.status = STATUS_RANGE;
               end else begin
                  rsp.read_value = store[pos];
               end
            end
            default: begin
            end
         endcase
         rsp.entry_count = 5'(held);
         rsp.is_empty = (held == 0);
         return rsp;
      endfunction

      function void note_request(req_type r);
         expected_results.push_back(predict_response(r));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
         end
         mismatches++;
      endtask

      task compare_field(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report_mismatch(what, got, want);
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result with no item waiting", 32'(got.status), '0);
         end else begin
            want = expected_results.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("read_value", got.read_value, want.read_value);
            compare_field("found", 32'(got.found), 32'(want.found));
            compare_field("found_index", 32'(got.found_index), 32'(want.found_index));
            compare_field("removed_count", 32'(got.removed_count),
                          32'(want.removed_count));
            compare_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            compare_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   table_scoreboard sb;
   int idle_pct [4] = '{0, 50, 21, 0};

   ordered_array_table_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results are taken at the edge that ends the strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_result(rsp_data);
      end
   end

   // hold the item until the block takes it, start stays high afterward
   task send_request(req_type r);
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_request(r);
   endtask

   task send_fields(logic [2:0] f, logic [3:0] pos, logic [31:0] value);
      req_type r;
      r.func = f;
      r.position = pos;
      r.item_value = value;
      send_request(r);
   endtask

   task pause_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // sender holds off until every result is back
   task wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // mostly valid positions, values often small or already held, some noise
   function automatic req_type random_request(bit filling);
      req_type r;
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      if (roll < 3) r.func = FUNC_UNUSED;
      else if (roll < (filling ? 45 : 20)) r.func = FUNC_APPEND;
      else if (roll < (filling ? 60 : 30)) r.func = FUNC_INSERT;
      else if (roll < (filling ? 68 : 50)) r.func = FUNC_POP;
      else if (roll < (filling ? 74 : 65)) r.func = FUNC_DELETE;
      else if (roll < (filling ? 80 : 75)) r.func = FUNC_REMOVE;
      else if (roll < 90) r.func = FUNC_FIND;
      else r.func = FUNC_READ;
      top = (sb.held > 15) ? 15 : sb.held;
      if ($urandom_range(0, 99) < 80) r.position = 4'($urandom_range(0, top));
      else r.position = 4'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 50) r.item_value = 32'($urandom_range(0, 5));
      else if (roll < 75 && sb.held > 0) r.item_value = sb.store[$urandom_range(0, sb.held - 1)];
      else r.item_value = $urandom();
      return r;
   endfunction

   initial begin
      int k;
      int p;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table cases and the unused selector
      send_fields(FUNC_POP, 4'd0, 32'd0);
      send_fields(FUNC_READ, 4'd0, 32'd0);
      send_fields(FUNC_DELETE, 4'd0, 32'd0);
      send_fields(FUNC_FIND, 4'd0, 32'd5);
      send_fields(FUNC_REMOVE, 4'd0, 32'd5);
      send_fields(FUNC_UNUSED, 4'd15, 32'hFFFF_FFFF);
      // fill to one short of full, extremes repeat for remove all
      for (k = 0; k < 15; k++) begin
         send_fields(FUNC_APPEND, 4'd0, (k % 3 == 0) ? 32'hFFFF_FFFF : 32'(k));
      end
      // insert at the end fills the table, then full cases
      send_fields(FUNC_INSERT, 4'd15, 32'd0);
      send_fields(FUNC_APPEND, 4'd0, 32'h1234_5678);
      send_fields(FUNC_INSERT, 4'd0, 32'h1234_5678);
      send_fields(FUNC_READ, 4'd15, 32'd0);
      send_fields(FUNC_REMOVE, 4'd0, 32'hFFFF_FFFF);
      // past the end cases with entries held
      send_fields(FUNC_INSERT, 4'd15, 32'hA5A5_A5A5);
      send_fields(FUNC_DELETE, 4'd15, 32'd0);
      send_fields(FUNC_FIND, 4'd0, 32'd7);
      send_fields(FUNC_FIND, 4'd0, 32'hDEAD_BEEF);
      send_fields(FUNC_INSERT, 4'd0, 32'h5A5A_5A5A);
      send_fields(FUNC_DELETE, 4'd2, 32'd0);
      send_fields(FUNC_POP, 4'd0, 32'd0);
      wait_drained();

      // random phases, some with idle gaps between items
      for (p = 0; p < 4; p++) begin
         for (k = 0; k < PHASE_ITEMS; k++) begin
            send_request(random_request(((k / 40) % 2) == 0));
            // the last item of a phase goes straight to the drain
            if (k + 1 < PHASE_ITEMS && $urandom_range(0, 99) < idle_pct[p]) begin
               pause_cycles($urandom_range(1, 6));
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report_mismatch("items left without a result", 32'(sb.pending()), '0);
      end
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
